@@ sv/hpc_pkg.sv @@
// shared types and constants for the hsv palette classifier
package hpc_pkg;

	localparam int HUE_W = 8;
	localparam int SAT_W = 8;
	localparam int TOL_W = 7;
	localparam int FIELD_W = 4;

	localparam logic [HUE_W-1:0] HUE_WRAP = 8'd180;
	localparam logic [SAT_W-1:0] SAT_LIMIT = 8'd30;
	localparam logic [TOL_W-1:0] TOL_RESET = 7'd10;

	typedef logic [FIELD_W-1:0] field_t;

	// controller to datapath
	typedef struct packed {
		logic load;    // capture sample, apply start of image
		logic rd_en;   // read one palette entry
		logic finish;  // resolve the sample and load the result register
		logic hit;     // with finish: the sample matched an entry
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic match;   // registered entry matches the sample
		logic full;    // palette holds the maximum number of entries
	} status_t;

endpackage

@@ sv/hpc_datapath.sv @@
// palette memory, sample registers, distance compare and result register
module hpc_datapath #(
	parameter int MAX_COLORS = 15,
	parameter int IDX_W = 4,
	parameter int CNT_W = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [hpc_pkg::TOL_W-1:0] cfg_data,
	input  logic                     start_image,
	input  logic [15:0]              sample_data,
	input  hpc_pkg::cmd_t            cmd,
	input  logic [IDX_W-1:0]         rd_addr,
	input  logic [IDX_W-1:0]         hit_idx,
	output hpc_pkg::status_t         status,
	output logic [CNT_W-1:0]         count,
	output logic [15:0]              result_data
);

	localparam int ENTRY_W = hpc_pkg::HUE_W + hpc_pkg::SAT_W;

	logic [hpc_pkg::TOL_W-1:0] tol_q;
	logic [hpc_pkg::HUE_W-1:0] hue_q;
	logic [hpc_pkg::SAT_W-1:0] sat_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      ovf_q;
	logic [ENTRY_W-1:0]        pal_mem [MAX_COLORS];
	logic [ENTRY_W-1:0]        rd_data_s1;
	logic [15:0]               result_q;

	logic [hpc_pkg::HUE_W-1:0] ent_hue;
	logic [hpc_pkg::SAT_W-1:0] ent_sat;
	logic [hpc_pkg::HUE_W-1:0] dh;
	logic [hpc_pkg::SAT_W-1:0] ds;
	logic [hpc_pkg::HUE_W-1:0] tol_ext;
	logic [hpc_pkg::HUE_W-1:0] wrap_lim;
	logic                      full;
	logic                      do_write;
	logic [IDX_W-1:0]          res_idx;
	logic                      res_new;
	logic [CNT_W-1:0]          cnt_next;
	logic                      ovf_next;

	assign ent_hue  = rd_data_s1[hpc_pkg::HUE_W-1:0];
	assign ent_sat  = rd_data_s1[ENTRY_W-1:hpc_pkg::HUE_W];
	assign dh       = (hue_q > ent_hue) ? hue_q - ent_hue : ent_hue - hue_q;
	assign ds       = (sat_q > ent_sat) ? sat_q - ent_sat : ent_sat - sat_q;
	assign tol_ext  = {1'b0, tol_q};
	// 180 minus a 7-bit tolerance never goes below zero
	assign wrap_lim = hpc_pkg::HUE_WRAP - tol_ext;

	assign status.match = ((dh < tol_ext) || (dh > wrap_lim)) && (ds < hpc_pkg::SAT_LIMIT);
	assign full         = (cnt_q == CNT_W'(MAX_COLORS));
	assign status.full  = full;
	assign count        = cnt_q;

	always_comb begin
		res_idx  = hit_idx;
		res_new  = 1'b0;
		cnt_next = cnt_q;
		ovf_next = ovf_q;
		do_write = 1'b0;
		if (!cmd.hit) begin
			if (!full) begin
				res_idx  = cnt_q[IDX_W-1:0];
				res_new  = 1'b1;
				cnt_next = cnt_q + 1'b1;
				do_write = 1'b1;
			end else begin
				res_idx  = '0;
				ovf_next = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= hpc_pkg::TOL_RESET;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				tol_q <= cfg_data;
			end
			if (cmd.load && start_image) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else if (cmd.finish) begin
				cnt_q <= cnt_next;
				ovf_q <= ovf_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			hue_q <= sample_data[7:0];
			sat_q <= sample_data[15:8];
		end
		if (cmd.finish) begin
			result_q <= {6'd0, ovf_next, hpc_pkg::field_t'(cnt_next), res_new,
				hpc_pkg::field_t'(res_idx)};
		end
	end

	// palette memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.finish && do_write) begin
			pal_mem[cnt_q[IDX_W-1:0]] <= {sat_q, hue_q};
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= pal_mem[rd_addr];
		end
	end

	assign result_data = result_q;

endmodule

@@ sv/hpc_ctrl.sv @@
// sequencer for the palette scan and the stream handshakes
module hpc_ctrl #(
	parameter int IDX_W = 4,
	parameter int CNT_W = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	input  hpc_pkg::status_t status,
	input  logic [CNT_W-1:0] count,
	output hpc_pkg::cmd_t    cmd,
	output logic [IDX_W-1:0] rd_addr,
	output logic [IDX_W-1:0] hit_idx
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_FINISH = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] ridx_q;
	logic             pv_s1;
	logic [IDX_W-1:0] cidx_s1;
	logic             hit_q;
	logic [IDX_W-1:0] hidx_q;
	logic             mvalid_q;
	logic             out_free;
	logic             found;
	logic             issue;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = mvalid_q;
	assign out_free = !mvalid_q || m_tready;
	assign found    = pv_s1 && status.match;
	assign issue    = (state_q == S_SCAN) && !found && (ridx_q != count);
	assign rd_addr  = ridx_q[IDX_W-1:0];
	assign hit_idx  = hidx_q;

	assign cmd.load   = s_tvalid && s_tready;
	assign cmd.rd_en  = issue;
	assign cmd.finish = (state_q == S_FINISH) && out_free;
	assign cmd.hit    = hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ridx_q   <= '0;
			pv_s1    <= 1'b0;
			cidx_s1  <= '0;
			hit_q    <= 1'b0;
			hidx_q   <= '0;
			mvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.load) begin
						state_q <= S_SCAN;
						ridx_q  <= '0;
						pv_s1   <= 1'b0;
					end
				end
				S_SCAN: begin
					pv_s1   <= issue;
					cidx_s1 <= ridx_q[IDX_W-1:0];
					if (found) begin
						hit_q   <= 1'b1;
						hidx_q  <= cidx_s1;
						state_q <= S_FINISH;
					end else if (ridx_q == count) begin
						hit_q   <= 1'b0;
						state_q <= S_FINISH;
					end else begin
						ridx_q <= ridx_q + 1'b1;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cmd.finish) begin
				mvalid_q <= 1'b1;
			end else if (m_tready) begin
				mvalid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> (CNT_W'(ridx_q) < count))
		else $error("palette read beyond entry count");
	a_finish_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!mvalid_q || m_tready))
		else $error("result overwritten before transfer");
	a_finish_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> mvalid_q)
		else $error("finished sample did not present a result");
	a_load_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_SCAN))
		else $error("accepted sample did not start a scan");
`endif

endmodule

@@ sv/hsv_palette_classifier.sv @@
// top level of the hsv palette classifier
// each sample is compared with the learned palette one entry per clock, lowest
// index first, through a registered read of the palette memory; the first hit
// ends the scan, so an early hit shortens it. one sample is worked on at a
// time. the result waits in an output register, and the next sample is taken
// as soon as the previous one has been resolved. the palette memory needs no
// clearing after reset: only entries below the entry count are ever read. the
// hue tolerance may be written at any time the block is idle
module hsv_palette_classifier #(
	parameter int MAX_COLORS = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: hue tolerance
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data,
	// sample stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] sample_hue, [15:8] sample_saturation
	input  logic        s_tuser,   // [0] start_image
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [3:0] color_index, [4] is_new_color,
	                               // [8:5] colors_in_use, [9] palette_overflow,
	                               // [15:10] zero
);

	// index width covers entries 0 .. MAX_COLORS-1, count width covers MAX_COLORS
	localparam int IDX_W = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
	localparam int CNT_W = $clog2(MAX_COLORS + 1);

	hpc_pkg::cmd_t    cmd;
	hpc_pkg::status_t status;
	logic [CNT_W-1:0] count;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] hit_idx;

	// tolerance register always takes a write
	assign cfg_ready = 1'b1;

	hpc_ctrl #(
		.IDX_W      (IDX_W),
		.CNT_W      (CNT_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.count    (count),
		.cmd      (cmd),
		.rd_addr  (rd_addr),
		.hit_idx  (hit_idx)
	);

	// palette, compare and result register
	hpc_datapath #(
		.MAX_COLORS (MAX_COLORS),
		.IDX_W      (IDX_W),
		.CNT_W      (CNT_W)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.start_image (s_tuser),
		.sample_data (s_tdata),
		.cmd         (cmd),
		.rd_addr     (rd_addr),
		.hit_idx     (hit_idx),
		.status      (status),
		.count       (count),
		.result_data (m_tdata)
	);

endmodule

@@ verif/hsv_palette_classifier_tb.sv @@
// self-checking testbench for the hsv palette classifier
module hsv_palette_classifier_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PALETTE_DEPTH = 15;
	// cycles with no transfer at all before the run is declared hung; receiver
	// stalls add to the time a full palette scan takes
	localparam int STALL_LIMIT = 4000;
	// quiet cycles after the last result, well beyond a full palette scan
	localparam int TAIL_CYCLES = 40;
	localparam int PHASE_ITEMS = 165;
	localparam int PHASES = 7;

	// result word as it sits on m_tdata, lowest field last
	typedef struct packed {
		logic [5:0]      pad;
		logic            palette_overflow;
		hpc_pkg::field_t colors_in_use;
		logic            is_new_color;
		hpc_pkg::field_t color_index;
	} color_word_t;

	// tracks the learned palette and holds the answers still owed by the block
	class palette_scoreboard;
		logic [hpc_pkg::HUE_W-1:0] hue_tab[PALETTE_DEPTH];
		logic [hpc_pkg::SAT_W-1:0] sat_tab[PALETTE_DEPTH];
		int unsigned               entries;
		logic                      overflow;
		logic [hpc_pkg::TOL_W-1:0] tolerance;
		color_word_t               pending_colors[$];
		int unsigned               errors;
		int unsigned               results_seen;
		int unsigned               new_colors;
		int unsigned               overflow_answers;

		function new();
			entries = 0;
			overflow = 1'b0;
			tolerance = hpc_pkg::TOL_RESET;
			errors = 0;
			results_seen = 0;
			new_colors = 0;
			overflow_answers = 0;
		endfunction

		function void set_tolerance(logic [hpc_pkg::TOL_W-1:0] tol);
			tolerance = tol;
		endfunction

		function int unsigned waiting();
			return pending_colors.size();
		endfunction

		// works out the answer for one accepted sample and updates the palette
		function void classify_sample(logic start, logic [hpc_pkg::HUE_W-1:0] hue,
		                              logic [hpc_pkg::SAT_W-1:0] sat);
			color_word_t ans;
			int dh;
			int ds;
			int k;
			int wrap_limit;
			bit hit;

			ans = '0;
			hit = 1'b0;
			if (start) begin
				entries = 0;
				overflow = 1'b0;
			end
			wrap_limit = int'(hpc_pkg::HUE_WRAP) - int'(tolerance);
			for (k = 0; k < int'(entries) && !hit; k++) begin
				dh = int'(hue) - int'(hue_tab[k]);
				ds = int'(sat) - int'(sat_tab[k]);
				if (dh < 0) dh = -dh;
				if (ds < 0) ds = -ds;
				if ((dh < int'(tolerance) || dh > wrap_limit) &&
				    ds < int'(hpc_pkg::SAT_LIMIT)) begin
					hit = 1'b1;
					ans.color_index = hpc_pkg::field_t'(k);
				end
			end
			if (!hit) begin
				if (entries >= PALETTE_DEPTH) begin
					overflow = 1'b1;
					ans.color_index = '0;
				end else begin
					hue_tab[entries] = hue;
					sat_tab[entries] = sat;
					ans.color_index = hpc_pkg::field_t'(entries);
					ans.is_new_color = 1'b1;
					entries++;
				end
			end
			ans.colors_in_use = hpc_pkg::field_t'(entries);
			ans.palette_overflow = overflow;
			pending_colors = {pending_colors, ans};
		endfunction

		function void report(string what, int unsigned want, logic [15:0] got);
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			errors++;
		endfunction

		// compares one result transfer with the oldest answer owed
		function void check_color_result(logic [15:0] word);
			color_word_t got;
			color_word_t want;

			got = word;
			if (pending_colors.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, actual %h", $time, word);
				errors++;
				return;
			end
			want = pending_colors.pop_front();
			results_seen++;
			if (want.is_new_color) new_colors++;
			if (!want.is_new_color && want.palette_overflow) overflow_answers++;
			if (got.color_index !== want.color_index)
				report("color_index", want.color_index, 16'(got.color_index));
			if (got.is_new_color !== want.is_new_color)
				report("is_new_color", want.is_new_color, 16'(got.is_new_color));
			if (got.colors_in_use !== want.colors_in_use)
				report("colors_in_use", want.colors_in_use, 16'(got.colors_in_use));
			if (got.palette_overflow !== want.palette_overflow)
				report("palette_overflow", want.palette_overflow, 16'(got.palette_overflow));
			if (got.pad !== want.pad)
				report("padding bits", want.pad, 16'(got.pad));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [6:0]  cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // [7:0] sample_hue, [15:8] sample_saturation
	logic        s_tuser = 1'b0; // [0] start_image
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // [3:0] color_index, [4] is_new_color,
	                             // [8:5] colors_in_use, [9] palette_overflow

	palette_scoreboard sb;
	bit          gaps_on = 1'b1;   // random idling on both sides
	int unsigned samples_sent = 0;
	int unsigned settings_used = 0;
	int unsigned quiet_cycles = 0;

	hsv_palette_classifier #(
		.MAX_COLORS(PALETTE_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver: backpressure in roughly a quarter of the cycles
	always @(posedge clk) begin
		m_tready <= gaps_on ? ($urandom_range(0, 99) >= 24) : 1'b1;
	end

	// result monitor: everything is driven by nonblocking assignment, so the
	// handshake seen here is the one that held before this edge
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_color_result(m_tdata);
	end

	// watchdog: any transfer on any channel restarts the count
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// one sample transfer, with random idle cycles in front of it
	task automatic send_sample(logic start, logic [hpc_pkg::HUE_W-1:0] hue,
	                           logic [hpc_pkg::SAT_W-1:0] sat);
		while (gaps_on && $urandom_range(0, 99) < 24) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {sat, hue};
		s_tuser <= start;
		do @(posedge clk); while (!s_tready);
		sb.classify_sample(start, hue, sat);
		samples_sent++;
	endtask

	// sender holds off until the block has answered every sample
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.waiting() != 0) @(posedge clk);
	endtask

	// only called with nothing in flight
	task automatic write_tolerance(logic [hpc_pkg::TOL_W-1:0] tol);
		cfg_valid <= 1'b1;
		cfg_data <= tol;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_tolerance(tol);
		settings_used++;
	endtask

	// hand-picked samples at the reset tolerance of 10
	task automatic run_directed();
		int k;
		send_sample(1'b1, 8'd0, 8'd0);       // opens an image, first entry
		send_sample(1'b0, 8'd179, 8'd10);    // hue wraps round onto entry 0
		send_sample(1'b0, 8'd255, 8'd255);   // top of both fields, hue out of range
		send_sample(1'b0, 8'd200, 8'd240);   // another out of range hue
		for (k = 0; k < 12; k++) begin
			send_sample(1'b0, 8'(20 + 15 * k), 8'd100);  // fills the palette
		end
		send_sample(1'b0, 8'd100, 8'd200);   // no match with the palette full
		send_sample(1'b0, 8'd50, 8'd110);    // still matched after the overflow
		send_sample(1'b1, 8'd90, 8'd128);    // new image clears palette and flag
	endtask

	// images built from a few base colours plus jitter around the tolerance
	// edges, with some stray samples and images that never got a start flag
	task automatic run_images(int unsigned quota);
		int unsigned sent;
		int unsigned n_colors;
		int unsigned len;
		int unsigned pick;
		int k;
		int tol;
		int h;
		int s;
		logic [hpc_pkg::HUE_W-1:0] base_hue[20];
		logic [hpc_pkg::SAT_W-1:0] base_sat[20];

		sent = 0;
		tol = int'(sb.tolerance);
		while (sent < quota) begin
			if ($urandom_range(0, 49) == 0) wait_drained();
			if ($urandom_range(0, 99) < 15) begin
				send_sample($urandom_range(0, 9) == 0, 8'($urandom_range(0, 255)),
				            8'($urandom_range(0, 255)));
				sent++;
			end else begin
				n_colors = $urandom_range(1, 19);
				len = $urandom_range(4, 40);
				for (k = 0; k < int'(n_colors); k++) begin
					base_hue[k] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(180, 255))
					                                          : 8'($urandom_range(0, 179));
					base_sat[k] = 8'($urandom_range(0, 255));
				end
				for (k = 0; k < int'(len) && sent < quota; k++) begin
					pick = $urandom_range(0, n_colors - 1);
					h = int'(base_hue[pick]) + int'($urandom_range(0, 2 * tol + 4)) - (tol + 2);
					s = int'(base_sat[pick]) + int'($urandom_range(0, 80)) - 40;
					if (base_hue[pick] < hpc_pkg::HUE_WRAP) h = ((h % 180) + 180) % 180;
					else if (h > 255) h = 255;
					else if (h < 0) h = 0;
					if (s > 255) s = 255;
					if (s < 0) s = 0;
					// most images open with the start flag, a few do not
					send_sample(k == 0 && $urandom_range(0, 9) != 0, 8'(h), 8'(s));
					sent++;
				end
			end
		end
	endtask

	initial begin
		int p;
		int tol_plan[PHASES];

		sb = new();
		tol_plan = '{0, 90, 127, 91, 0, 0, 10};
		tol_plan[4] = $urandom_range(1, 89);
		tol_plan[5] = $urandom_range(0, 127);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		for (p = 0; p < PHASES; p++) begin
			wait_drained();
			write_tolerance(7'(tol_plan[p]));
			// the widest tolerance runs with no idling anywhere
			gaps_on = (p != 2);
			run_images(PHASE_ITEMS);
		end
		gaps_on = 1'b1;

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.waiting() != 0) begin
			$display("%0t ns: %0d results never arrived", $time, sb.waiting());
			sb.errors++;
		end

		$display("run covered %0d samples over %0d tolerance settings",
		         samples_sent, settings_used + 1);
		$display("%0d results checked: %0d new colours, %0d overflow answers, %0d errors",
		         sb.results_seen, sb.new_colors, sb.overflow_answers, sb.errors);
		if (sb.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
sv/hpc_pkg.sv
sv/hpc_datapath.sv
sv/hpc_ctrl.sv
sv/hsv_palette_classifier.sv
verif/hsv_palette_classifier_tb.sv
